@@ design/rsm_pkg.sv @@
// ----------------------------------------------------------------------------
// rsm_pkg
// shared types, constants and the exponent table of the row softmax unit
// ----------------------------------------------------------------------------
`default_nettype none

package rsm_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int CNT_W        = 7;
  localparam int SCORE_W      = 16;
  localparam int EXP_W        = 16;
  localparam int SUM_W        = 23;
  localparam int EXP_CUTOFF   = 12;
  localparam int SERIES_TERMS = 16;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      row_end;
  } rsm_in_t;

  typedef struct packed {
    logic [15:0] prob;
    logic [5:0]  elem_index;
    logic        final_elem;
    logic        overflowed;
  } rsm_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    logic signed [SCORE_W-1:0] row_max;
    logic                      ovf;
  } rsm_desc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_GO,
    S_EXP_WAIT,
    S_DIV_RD,
    S_DIV_GO,
    S_DIV_RUN
  } rsm_state_e;

  typedef logic [31:0] exp_frac_t [256];

  // exp(-t), t in q1.31, truncating series
  function automatic logic [31:0] neg_exp_q31(input logic [63:0] t);
    logic [63:0]        term;
    logic signed [63:0] acc;
    term = 64'h8000_0000;
    acc  = 64'sh8000_0000;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * t) >> 31) / 64'(k);
      if ((k % 2) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    return acc[31:0];
  endfunction

  function automatic exp_frac_t build_exp_frac();
    exp_frac_t tbl;
    for (int b = 0; b < 256; b++) begin
      tbl[b] = neg_exp_q31(64'(b) << 23);
    end
    return tbl;
  endfunction

  localparam exp_frac_t   EXP_FRAC = build_exp_frac();
  localparam logic [31:0] EXP_E1   = neg_exp_q31(64'h8000_0000);

endpackage

`default_nettype wire

@@ design/rsm_front.sv @@
// ----------------------------------------------------------------------------
// rsm_front
// accepts scores, stores them, tracks row max and hands finished rows on
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_front #(
  parameter int MAX_COLS = rsm_pkg::MAX_COLS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rsm_pkg::rsm_in_t            in_i,
  input  wire logic [$clog2(MAX_COLS)-1:0] rd_addr_i,
  output logic [rsm_pkg::SCORE_W-1:0]      rd_data_o,
  output logic                             push_o,
  output rsm_pkg::rsm_desc_t               desc_o,
  input  wire logic                        row_done_i
);

  localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FILL_W = $clog2(MAX_COLS + 1);

  logic [rsm_pkg::SCORE_W-1:0] score_buf [MAX_COLS];

  logic [FILL_W-1:0]                  fill_q, fill_d, fill_n;
  logic signed [rsm_pkg::SCORE_W-1:0] max_q, max_d, max_n;
  logic                               ovf_q, ovf_d, ovf_n;
  logic                               busy_q, busy_d;
  logic                               accept, has_room;

  assign busy     = busy_q;
  assign accept   = start && !busy_q;
  assign has_room = fill_q < FILL_W'(MAX_COLS);

  always_comb begin
    fill_n = fill_q;
    max_n  = max_q;
    ovf_n  = ovf_q;
    if (has_room) begin
      fill_n = fill_q + FILL_W'(1);
      if (in_i.score > max_q) begin
        max_n = in_i.score;
      end
    end else begin
      ovf_n = 1'b1;
    end
  end

  always_comb begin
    fill_d = fill_q;
    max_d  = max_q;
    ovf_d  = ovf_q;
    busy_d = busy_q;
    push_o = 1'b0;
    desc_o.count   = rsm_pkg::CNT_W'(fill_n);
    desc_o.row_max = max_n;
    desc_o.ovf     = ovf_n;
    if (accept) begin
      fill_d = fill_n;
      max_d  = max_n;
      ovf_d  = ovf_n;
      if (in_i.row_end) begin
        push_o = 1'b1;
        fill_d = '0;
        max_d  = {1'b1, {(rsm_pkg::SCORE_W-1){1'b0}}};
        ovf_d  = 1'b0;
        busy_d = 1'b1;
      end
    end
    if (row_done_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      max_q  <= {1'b1, {(rsm_pkg::SCORE_W-1){1'b0}}};
      ovf_q  <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      max_q  <= max_d;
      ovf_q  <= ovf_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_room) begin
      score_buf[fill_q[IDX_W-1:0]] <= in_i.score;
    end
    rd_data_o <= score_buf[rd_addr_i];
  end

endmodule

`default_nettype wire

@@ design/rsm_queue.sv @@
// ----------------------------------------------------------------------------
// rsm_queue
// two-entry queue of row descriptors between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rsm_pkg::rsm_desc_t desc_i,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output rsm_pkg::rsm_desc_t      head_o
);

  rsm_pkg::rsm_desc_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

@@ design/rsm_exp.sv @@
// ----------------------------------------------------------------------------
// rsm_exp
// iterative exponent unit, one multiply by exp(-1) per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_exp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [15:0]          d_i,
  output logic                      done_o,
  output logic [rsm_pkg::EXP_W-1:0] e_o
);

  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [31:0] r_q;
  logic [63:0] prod;
  logic [32:0] rnd;
  logic [17:0] e_full;

  assign prod   = 64'(r_q) * 64'(rsm_pkg::EXP_E1);
  assign rnd    = 33'(r_q) + 33'h4000;
  assign e_full = rnd[32:15];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == 4'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        if (d_i[15:8] >= 8'(rsm_pkg::EXP_CUTOFF)) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= d_i[11:8];
        end
      end else if (busy_q) begin
        if (cnt_q != 4'd0) begin
          cnt_q <= cnt_q - 4'd1;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (d_i[15:8] >= 8'(rsm_pkg::EXP_CUTOFF)) begin
        r_q <= '0;
      end else begin
        r_q <= rsm_pkg::EXP_FRAC[d_i[7:0]];
      end
    end else if (busy_q) begin
      if (cnt_q != 4'd0) begin
        r_q <= prod[62:31];
      end else begin
        e_o <= (e_full > 18'd65535) ? 16'hFFFF : e_full[15:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/rsm_back.sv @@
// ----------------------------------------------------------------------------
// rsm_back
// runs a stored row: exponent and sum pass, then one divide per element
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_back #(
  parameter int MAX_COLS = rsm_pkg::MAX_COLS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  wire rsm_pkg::rsm_desc_t          head_i,
  output logic                             pop_o,
  output logic [$clog2(MAX_COLS)-1:0]      rd_addr_o,
  input  wire logic [rsm_pkg::SCORE_W-1:0] rd_data_i,
  output logic                             row_done_o,
  output logic                             result_valid_o,
  output rsm_pkg::rsm_out_t                res_o
);

  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [rsm_pkg::EXP_W-1:0] exp_buf [MAX_COLS];

  rsm_pkg::rsm_state_e               state_q, state_d;
  logic [IDX_W-1:0]                  idx_q;
  logic [rsm_pkg::CNT_W-1:0]         n_q;
  logic signed [rsm_pkg::SCORE_W-1:0] max_q;
  logic                              ovf_q;
  logic [rsm_pkg::SUM_W-1:0]         sum_q;
  logic [31:0]                       dvd_q;
  logic [rsm_pkg::SUM_W:0]           rem_q, rem_sh;
  logic [4:0]                        step_q;
  logic [rsm_pkg::EXP_W-1:0]         exp_rd_q;
  logic                              valid_q;
  rsm_pkg::rsm_out_t                 res_q;

  logic                      last_idx, ge, exp_start, exp_done, div_end;
  logic [rsm_pkg::EXP_W-1:0] exp_e;
  logic [15:0]               gap;
  logic [31:0]               q_fin;

  assign last_idx = (rsm_pkg::CNT_W'(idx_q) == n_q - rsm_pkg::CNT_W'(1));
  assign gap      = 16'(max_q - $signed(rd_data_i));
  assign rem_sh   = {rem_q[rsm_pkg::SUM_W-1:0], dvd_q[31]};
  assign ge       = rem_sh >= {1'b0, sum_q};
  assign q_fin    = {dvd_q[30:0], ge};
  assign div_end  = (state_q == rsm_pkg::S_DIV_RUN) && (step_q == 5'd31);
  assign rd_addr_o      = idx_q;
  assign result_valid_o = valid_q;
  assign res_o          = res_q;

  rsm_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .d_i     (gap),
    .done_o  (exp_done),
    .e_o     (exp_e)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsm_pkg::S_IDLE: begin
        if (!empty_i) state_d = rsm_pkg::S_EXP_RD;
      end
      rsm_pkg::S_EXP_RD:   state_d = rsm_pkg::S_EXP_GO;
      rsm_pkg::S_EXP_GO:   state_d = rsm_pkg::S_EXP_WAIT;
      rsm_pkg::S_EXP_WAIT: begin
        if (exp_done) state_d = last_idx ? rsm_pkg::S_DIV_RD : rsm_pkg::S_EXP_RD;
      end
      rsm_pkg::S_DIV_RD:   state_d = rsm_pkg::S_DIV_GO;
      rsm_pkg::S_DIV_GO:   state_d = rsm_pkg::S_DIV_RUN;
      rsm_pkg::S_DIV_RUN: begin
        if (step_q == 5'd31) state_d = last_idx ? rsm_pkg::S_IDLE : rsm_pkg::S_DIV_RD;
      end
      default: state_d = rsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = (state_q == rsm_pkg::S_IDLE) && !empty_i;
    exp_start  = (state_q == rsm_pkg::S_EXP_GO);
    row_done_o = div_end && last_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsm_pkg::S_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= div_end;
      if (pop_o) begin
        idx_q <= '0;
      end
      if ((state_q == rsm_pkg::S_EXP_WAIT) && exp_done) begin
        idx_q <= last_idx ? '0 : idx_q + IDX_W'(1);
      end
      if (state_q == rsm_pkg::S_DIV_GO) begin
        step_q <= '0;
      end
      if (state_q == rsm_pkg::S_DIV_RUN) begin
        step_q <= step_q + 5'd1;
      end
      if (div_end) begin
        idx_q   <= last_idx ? '0 : idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      n_q   <= head_i.count;
      max_q <= head_i.row_max;
      ovf_q <= head_i.ovf;
      sum_q <= '0;
    end
    if ((state_q == rsm_pkg::S_EXP_WAIT) && exp_done) begin
      sum_q <= sum_q + rsm_pkg::SUM_W'(exp_e);
    end
    if (state_q == rsm_pkg::S_DIV_GO) begin
      dvd_q <= {exp_rd_q, 16'h0000};
      rem_q <= '0;
    end
    if (state_q == rsm_pkg::S_DIV_RUN) begin
      rem_q <= ge ? rem_sh - {1'b0, sum_q} : rem_sh;
      dvd_q <= q_fin;
    end
    if (div_end) begin
      res_q.prob       <= (q_fin[31:16] != 16'h0000) ? 16'hFFFF : q_fin[15:0];
      res_q.elem_index <= 6'(idx_q);
      res_q.final_elem <= last_idx;
      res_q.overflowed <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == rsm_pkg::S_EXP_WAIT) && exp_done) begin
      exp_buf[idx_q] <= exp_e;
    end
    exp_rd_q <= exp_buf[idx_q];
  end

endmodule

`default_nettype wire

@@ design/rowwise_softmax_unit.sv @@
// ----------------------------------------------------------------------------
// rowwise_softmax_unit
// max-subtracted softmax over one row of signed q8.8 scores
// ----------------------------------------------------------------------------
// Scores are taken one beat per cycle while busy is low; the beat carrying
// row_end closes the row and busy stays high until the last probability of
// that row appears. Each element then goes through the exponent unit
// (one multiply per integer part of the distance to the max) and, once the
// row sum is complete, through the bit-serial divider. Each result is shown
// for one cycle with result_valid_o; the receiver cannot stall, so results
// must be taken then.
`default_nettype none

module rowwise_softmax_unit #(
  parameter int MAX_COLS = rsm_pkg::MAX_COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rsm_pkg::rsm_in_t in_i,
  output logic                  result_valid_o,
  output rsm_pkg::rsm_out_t     res_o
);

  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic                        push, pop, empty, row_done;
  rsm_pkg::rsm_desc_t          desc, head;
  logic [IDX_W-1:0]            rd_addr;
  logic [rsm_pkg::SCORE_W-1:0] rd_data;

  rsm_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .push_o     (push),
    .desc_o     (desc),
    .row_done_i (row_done)
  );

  rsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  rsm_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .row_done_o     (row_done),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  a_busy_midrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !res_o.final_elem) |-> busy)
    else $error("result beat while front idle");

  a_busy_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.row_end) |=> busy)
    else $error("row end did not raise busy");

  a_nonempty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (head.count != '0))
    else $error("empty row handed to back");

endmodule

`default_nettype wire

@@ verif/rsm_checker.sv @@
// ----------------------------------------------------------------------------
// rsm_checker
// watches the score and probability channels, predicts every probability of
// a row and compares each result beat field by field against the oldest one
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rsm_checker #(
  parameter int MAX_COLS = rsm_pkg::MAX_COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire rsm_pkg::rsm_in_t in_i,
  input  wire logic             result_valid_o,
  input  wire rsm_pkg::rsm_out_t res_o,
  output int                    fail_cnt,
  output int                    pending
);

  rsm_pkg::rsm_out_t  prob_q[$];
  logic signed [15:0] row_scores[$];
  logic signed [15:0] row_peak;
  logic               row_lost;

  // exp(-t), t in q1.31
  function automatic logic [63:0] decay_series(input logic [63:0] t);
    logic [63:0]        term;
    logic signed [63:0] acc;
    term = 64'd1 << 31;
    acc  = 64'sd1 <<< 31;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * t) >> 31) / k;
      if (k % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  function automatic logic [15:0] weight_of(input logic [15:0] dist_v);
    logic [63:0] r, e1;
    int          whole;
    whole = dist_v >> 8;
    if (whole >= 12) return 16'd0;
    r  = decay_series(64'(dist_v[7:0]) << 23);
    e1 = decay_series(64'd1 << 31);
    repeat (whole) r = (r * e1) >> 31;
    r = (r + (64'd1 << 14)) >> 15;
    return (r > 65535) ? 16'hffff : r[15:0];
  endfunction

  task automatic close_row();
    logic [15:0]       w[$];
    logic [22:0]       total;
    logic [63:0]       p;
    rsm_pkg::rsm_out_t o;
    total = '0;
    foreach (row_scores[k]) begin
      w.push_back(weight_of(16'(32'(row_peak) - 32'(row_scores[k]))));
      total = total + 23'(w[k]);
    end
    foreach (w[k]) begin
      p = (total == 0) ? 64'd0 : (64'(w[k]) << 16) / total;
      o.prob       = (p > 65535) ? 16'hffff : p[15:0];
      o.elem_index = 6'(k);
      o.final_elem = (k == w.size() - 1);
      o.overflowed = row_lost;
      prob_q.push_back(o);
    end
    row_scores.delete();
    row_peak = -16'sd32768;
    row_lost = 1'b0;
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (fail_cnt < 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsm_pkg::rsm_out_t want;
    if (!rst_ni) begin
      row_scores.delete();
      prob_q.delete();
      row_peak = -16'sd32768;
      row_lost = 1'b0;
      fail_cnt = 0;
      pending  = 0;
    end else begin
      if (result_valid_o) begin
        if (prob_q.size() == 0) begin
          report("unexpected beat, prob", 0, res_o.prob);
        end else begin
          want = prob_q.pop_front();
          if (res_o.prob !== want.prob) report("prob", want.prob, res_o.prob);
          if (res_o.elem_index !== want.elem_index)
            report("elem_index", want.elem_index, res_o.elem_index);
          if (res_o.final_elem !== want.final_elem)
            report("final_elem", want.final_elem, res_o.final_elem);
          if (res_o.overflowed !== want.overflowed)
            report("overflowed", want.overflowed, res_o.overflowed);
        end
      end
      if (start && !busy) begin
        if (row_scores.size() < MAX_COLS) begin
          row_scores.push_back(in_i.score);
          if (in_i.score > row_peak) row_peak = in_i.score;
        end else begin
          row_lost = 1'b1;
        end
        if (in_i.row_end) close_row();
      end
      pending = prob_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives rows of q8.8 scores into the row softmax unit with random gaps,
// directed extremes and overflowing rows; rsm_checker judges the results
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rsm_pkg::rsm_in_t  in_i = '0;
  logic              result_valid_o;
  rsm_pkg::rsm_out_t res_o;
  int                fail_cnt, pending, cycles = 0, sent = 0;
  bit                calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rowwise_softmax_unit dut (.*);

  rsm_checker u_checker (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [15:0] s, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    in_i.score = s;
    in_i.row_end = last;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic send_row(input int len);
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: send_beat(16'($urandom), i == len - 1);
        1: send_beat(16'($urandom_range(0, 2047)) - 16'd1024, i == len - 1);
        default: send_beat(16'($urandom_range(0, 1023)), i == len - 1);
      endcase
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int len;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed rows
    send_beat(16'h7fff, 1'b1);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7fff, 1'b1);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0100, 1'b0);
    send_beat(16'hff00, 1'b1);
    send_beat(16'h0c00, 1'b0);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h0bff, 1'b1);
    send_beat(16'h1234, 1'b0);
    send_beat(16'h1234, 1'b0);
    send_beat(16'h1234, 1'b1);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h8000, 1'b1);
    drain();
    // full row plus dropped scores
    for (int i = 0; i < 66; i++) send_beat(16'($urandom), i == 65);
    drain();
    while (sent < 168) begin
      calm = (sent > 140);
      len = ($urandom_range(0, 9) == 0 && sent < 100) ? $urandom_range(60, 67)
                                                       : $urandom_range(1, 8);
      send_row(len);
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rsm_pkg.sv
design/rsm_front.sv
design/rsm_queue.sv
design/rsm_exp.sv
design/rsm_back.sv
design/rowwise_softmax_unit.sv
verif/rsm_checker.sv
verif/testbench.sv
